### rtl/sdff_pkg.sv
// Shared types and constants for the signed decimal field formatter.
// Holds the character codes, the control word layout and the microcode table.
// No dependencies; the sequencer, datapath, top level, checker and testbench import it.
package sdff_pkg;

  localparam logic [6:0]  CHAR_ZERO  = 7'd48;
  localparam logic [6:0]  CHAR_MINUS = 7'd45;
  localparam logic [6:0]  CHAR_SPACE = 7'd32;

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  // Step addresses of the microprogram.
  localparam pc_t ST_IDLE  = 3'd0;
  localparam pc_t ST_SIGN  = 3'd1;
  localparam pc_t ST_ZERO  = 3'd2;
  localparam pc_t ST_DTEST = 3'd3;
  localparam pc_t ST_DIGIT = 3'd4;
  localparam pc_t ST_PTEST = 3'd5;
  localparam pc_t ST_PAD   = 3'd6;

  typedef enum logic [1:0] {
    CH_SIGN,
    CH_ZERO,
    CH_DIGIT,
    CH_SPACE
  } char_sel_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_MAG_NONZERO,
    C_DIGITS_DONE,
    C_PAD_DONE
  } cond_t;

  typedef struct packed {
    logic      accept;
    logic      emit;
    char_sel_t ch;
    cond_t     cond;
    pc_t       target;
  } cw_t;

  typedef struct packed {
    logic out_free;
    logic mag_zero;
    logic digits_done;
    logic pad_done;
  } stat_t;

  // Microprogram. A step jumps to target when its condition holds and
  // otherwise falls through to the next step; a placing step waits for a free output register.
  function automatic cw_t sdff_rom(input pc_t addr);
    cw_t w;
    w = '{accept: 1'b0, emit: 1'b0, ch: CH_SIGN, cond: C_ALWAYS, target: ST_IDLE};
    unique case (addr)
      ST_IDLE:  w = '{accept: 1'b1, emit: 1'b0, ch: CH_SIGN,  cond: C_NO_INPUT,
                      target: ST_IDLE};
      ST_SIGN:  w = '{accept: 1'b0, emit: 1'b1, ch: CH_SIGN,  cond: C_MAG_NONZERO,
                      target: ST_DTEST};
      ST_ZERO:  w = '{accept: 1'b0, emit: 1'b1, ch: CH_ZERO,  cond: C_ALWAYS,
                      target: ST_PTEST};
      ST_DTEST: w = '{accept: 1'b0, emit: 1'b0, ch: CH_DIGIT, cond: C_DIGITS_DONE,
                      target: ST_PTEST};
      ST_DIGIT: w = '{accept: 1'b0, emit: 1'b1, ch: CH_DIGIT, cond: C_ALWAYS,
                      target: ST_DTEST};
      ST_PTEST: w = '{accept: 1'b0, emit: 1'b0, ch: CH_SPACE, cond: C_PAD_DONE,
                      target: ST_IDLE};
      ST_PAD:   w = '{accept: 1'b0, emit: 1'b1, ch: CH_SPACE, cond: C_ALWAYS,
                      target: ST_PTEST};
      default:  w = '{accept: 1'b0, emit: 1'b0, ch: CH_SIGN,  cond: C_ALWAYS,
                      target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/sdff_in_if.sv
// Request channel of the formatter: valid/ready handshake and the number to show.
// Stands alone; the value width follows the VALUE_BITS parameter.
interface sdff_in_if #(parameter int VALUE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   start_column;
  logic [1:0]                   text_row;
  logic signed [VALUE_BITS-1:0] value;
  logic [4:0]                   field_width;

  modport source (output valid, start_column, text_row, value, field_width, input ready);
  modport sink   (input valid, start_column, text_row, value, field_width, output ready);
endinterface

### rtl/sdff_out_if.sv
// Result channel of the formatter: valid/ready handshake and one character placement.
// Stands alone; all fields have fixed widths.
interface sdff_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] cell_column;
  logic [1:0] cell_row;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, cell_column, cell_row, char_code, last, input ready);
  modport sink   (input valid, cell_column, cell_row, char_code, last, output ready);
endinterface

### rtl/sdff_seq.sv
// Microcode sequencer: step counter, control word table and conditional jumps.
// Depends on sdff_pkg for the control word, status struct and table.
module sdff_seq import sdff_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output cw_t   cw
);

  pc_t  pc;
  pc_t  pc_next;
  logic cond_met;
  logic hold;

  assign cw = sdff_rom(pc);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:      cond_met = 1'b1;
      C_NO_INPUT:    cond_met = !in_valid;
      C_MAG_NONZERO: cond_met = !stat.mag_zero;
      C_DIGITS_DONE: cond_met = stat.digits_done;
      C_PAD_DONE:    cond_met = stat.pad_done;
      default:       cond_met = 1'b1;
    endcase
  end

  // A step that places a character waits until the output register is free.
  assign hold = cw.emit && !stat.out_free;

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (cond_met) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/sdff_dp.sv
// Formatter datapath: operand registers, divide-by-ten unit, placement counter
// and the output register. Depends on sdff_pkg; steered by the sequencer's control word.
module sdff_dp import sdff_pkg::*; #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_WIDTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cw_t                          cw,
  input  logic                         in_valid,
  input  logic [3:0]                   start_column,
  input  logic [1:0]                   text_row,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [4:0]                   field_width,
  output stat_t                        stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [4:0]                   cell_column,
  output logic [1:0]                   cell_row,
  output logic [6:0]                   char_code,
  output logic                         last
);

  localparam int             CNT_W = $clog2(MAX_WIDTH + 1);
  localparam logic [CNT_W:0] ONE   = (CNT_W + 1)'(1);
  localparam logic [CNT_W:0] TWO   = (CNT_W + 1)'(2);

  logic [3:0]            col_base;
  logic [1:0]            row;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [CNT_W-1:0]      w;
  logic [CNT_W-1:0]      p;
  logic [63:0]           prod;

  logic                  load;
  logic                  out_free;
  logic                  do_emit;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic [CNT_W-1:0]      w_in;
  logic [CNT_W:0]        p_ext;
  logic [CNT_W:0]        w_ext;
  logic [31:0]           mag32;
  logic [VALUE_BITS-1:0] q;
  logic [VALUE_BITS-1:0] rem;
  logic [3:0]            digit;
  logic                  mag_zero;
  logic [4:0]            col_next;
  logic [6:0]            char_next;
  logic                  last_next;

  assign load     = cw.accept && in_valid;
  assign out_free = !out_valid || out_ready;
  assign do_emit  = cw.emit && out_free;

  // Two's complement magnitude; the most negative value comes out as its
  // unsigned magnitude since the register is unsigned.
  assign raw    = VALUE_BITS'(value);
  assign mag_in = value[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    if (field_width == 5'd0) begin
      w_in = CNT_W'(1);
    end else if ({1'b0, field_width} > 6'(MAX_WIDTH)) begin
      w_in = CNT_W'(MAX_WIDTH);
    end else begin
      w_in = CNT_W'(field_width);
    end
  end

  assign p_ext = {1'b0, p};
  assign w_ext = {1'b0, w};

  // Quotient from the registered reciprocal product; remainder by shifts.
  assign mag32 = 32'(mag);
  assign q     = VALUE_BITS'(prod[63:RECIP10_SHIFT]);
  assign rem   = mag - ((q << 3) + (q << 1));
  assign digit = rem[3:0];

  assign mag_zero         = (mag == '0);
  assign stat.out_free    = out_free;
  assign stat.mag_zero    = mag_zero;
  assign stat.digits_done = mag_zero || (p_ext >= w_ext);
  assign stat.pad_done    = (p_ext + ONE) >= w_ext;

  always_comb begin
    col_next = {1'b0, col_base} + 5'(w) - 5'(p) - 5'd1;
    case (cw.ch)
      CH_SIGN: begin
        col_next  = {1'b0, col_base};
        char_next = neg ? CHAR_MINUS : CHAR_SPACE;
        last_next = 1'b0;
      end
      CH_ZERO: begin
        char_next = CHAR_ZERO;
        last_next = TWO >= w_ext;
      end
      CH_DIGIT: begin
        char_next = CHAR_ZERO + {3'b000, digit};
        last_next = ((q == '0) || ((p_ext + ONE) >= w_ext)) && ((p_ext + TWO) >= w_ext);
      end
      default: begin
        char_next = CHAR_SPACE;
        last_next = (p_ext + TWO) >= w_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mag32) * 64'(RECIP10);
    if (load) begin
      col_base <= start_column;
      row      <= text_row;
      neg      <= value[VALUE_BITS-1];
      mag      <= mag_in;
      w        <= w_in;
      p        <= '0;
    end else if (do_emit && (cw.ch != CH_SIGN)) begin
      p <= p + CNT_W'(1);
      if (cw.ch == CH_DIGIT) begin
        mag <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      cell_column <= col_next;
      cell_row    <= row;
      char_code   <= char_next;
      last        <= last_next;
    end
  end

endmodule

### rtl/signed_decimal_field_formatter.sv
// Top level of the signed decimal field formatter.
// Depends on sdff_pkg, sdff_in_if, sdff_out_if, sdff_seq and sdff_dp.
//
// Usage: each request on in_ch carries a signed value, a text row, a start
// column and a field width. The block answers with a run of character
// placements on out_ch. The first placement is the sign cell at the start
// column ('-' or blank). The digits follow right-justified, least significant
// first, and blanks pad the field down to the cell after the sign. A zero
// value shows a single '0' in the rightmost cell. The width is saturated to
// 1..MAX_WIDTH, and digits that do not fit are dropped. The final placement
// of a run carries last = 1.
//
// Timing: one request is handled at a time. The idle step accepts a request
// and the sign step places the first cell, which shows on out_ch once the
// output register takes it. Each decimal digit passes a test step, while the
// reciprocal product is registered, and then a placing step.
//
// Reset returns the sequencer to its idle step and empties the output
// register. While the receiver stalls, the pending placement holds in the
// output register and the sequencer waits on the next placing step.
module signed_decimal_field_formatter import sdff_pkg::*; #(
  parameter int VALUE_BITS = 16,
  parameter int MAX_WIDTH  = 16
) (
  input logic    clk,
  input logic    rst,
  sdff_in_if.sink     in_ch,
  sdff_out_if.source  out_ch
);

  cw_t   cw;
  stat_t stat;

  // Requests are taken only on the idle step of the microprogram.
  assign in_ch.ready = cw.accept;

  sdff_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cw       (cw)
  );

  sdff_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cw           (cw),
    .in_valid     (in_ch.valid),
    .start_column (in_ch.start_column),
    .text_row     (in_ch.text_row),
    .value        (in_ch.value),
    .field_width  (in_ch.field_width),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cell_column  (out_ch.cell_column),
    .cell_row     (out_ch.cell_row),
    .char_code    (out_ch.char_code),
    .last         (out_ch.last)
  );

endmodule

### rtl/sdff_chk.sv
// Port-level checks for the signed decimal field formatter.
// Depends on sdff_pkg for the character codes and on the top level's ports; bound below.
module sdff_chk import sdff_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] cell_column,
  input logic [1:0] cell_row,
  input logic [6:0] char_code,
  input logic       last
);

  // A stalled placement stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_column) && $stable(cell_row)
      && $stable(char_code) && $stable(last))
    else $error("stalled placement changed");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Only a sign, a blank or a decimal digit is ever placed.
  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CHAR_MINUS) || (char_code == CHAR_SPACE)
      || ((char_code >= CHAR_ZERO) && (char_code <= (CHAR_ZERO + 7'd9))))
    else $error("bad character code");

  // Reset leaves the block idle with nothing to deliver.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind signed_decimal_field_formatter sdff_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cell_column (out_ch.cell_column),
  .cell_row    (out_ch.cell_row),
  .char_code   (out_ch.char_code),
  .last        (out_ch.last)
);

### test/signed_decimal_field_formatter_test.sv
// Self-checking testbench for signed_decimal_field_formatter.
// Depends on sdff_pkg, sdff_in_if, sdff_out_if and the formatter RTL; reads no files.
// A queue of predicted cell placements is compared with every placement the block emits.
module signed_decimal_field_formatter_test;
  import sdff_pkg::*;

  localparam int VALUE_BITS = 16;
  localparam int FIELD_MAX  = 16;
  localparam int RANDOM_REQUESTS = 300;
  // The slowest correct run covers about 325 requests, each with up to 17
  // placements that the receiver may stall, plus sender gaps.
  // The limit lies well above that.
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 2 * FIELD_MAX + 8;

  // One character placement as it leaves the block.
  typedef struct packed {
    logic [4:0] column;
    logic [1:0] row;
    logic [6:0] code;
    logic       last;
  } placement_t;

  // Holds the placements that requests accepted so far must still produce.
  // Each request is laid out here in the same order the block emits it.
  class placement_board;
    placement_t due[$];
    int errors = 0;
    int placed = 0;

    function void place(int column, logic [1:0] row, logic [6:0] code);
      placement_t slot;
      slot.column = column[4:0];
      slot.row    = row;
      slot.code   = code;
      slot.last   = 1'b0;
      due.push_back(slot);
    endfunction

    // Lays out one accepted request: sign cell, then digits right-justified,
    // then blank padding down to the cell after the sign.
    function void note_request(logic [3:0] col, logic [1:0] row,
                               logic signed [VALUE_BITS-1:0] val, logic [4:0] width);
      int  w;
      int  p;
      int  mag;
      bit  neg;
      w = (width == 5'd0) ? 1 : ((int'(width) > FIELD_MAX) ? FIELD_MAX : int'(width));
      neg = val[VALUE_BITS-1];
      // The magnitude is formed in 32 bits, so the most negative value is exact.
      mag = neg ? -int'(val) : int'(val);
      p = 0;
      place(col, row, neg ? CHAR_MINUS : CHAR_SPACE);
      if (mag == 0) begin
        place(col + w - 1, row, CHAR_ZERO);
        p = 1;
      end
      while (mag > 0 && p < w) begin
        place(col + w - p - 1, row, CHAR_ZERO + 7'(mag % 10));
        p++;
        mag = mag / 10;
      end
      while (p + 1 < w) begin
        place(col + w - p - 1, row, CHAR_SPACE);
        p++;
      end
      due[due.size() - 1].last = 1'b1;
    endfunction

    function void check_placement(placement_t got);
      placement_t want;
      placed++;
      if (due.size() == 0) begin
        $error("unexpected placement: cell_column %0d cell_row %0d char_code %0d last %0d",
               got.column, got.row, got.code, got.last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.column !== want.column) begin
        $error("cell_column: expected %0d, actual %0d", want.column, got.column);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("cell_row: expected %0d, actual %0d", want.row, got.row);
        errors++;
      end
      if (got.code !== want.code) begin
        $error("char_code: expected %0d, actual %0d", want.code, got.code);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   requests_sent = 0;
  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  placement_board board = new();

  sdff_in_if #(.VALUE_BITS(VALUE_BITS)) req_ch();
  sdff_out_if cell_ch();

  signed_decimal_field_formatter #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (FIELD_MAX)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (req_ch),
    .out_ch(cell_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every input of the block is known from time zero.
  initial begin
    req_ch.valid        = 1'b0;
    req_ch.start_column = '0;
    req_ch.text_row     = '0;
    req_ch.value        = '0;
    req_ch.field_width  = '0;
    cell_ch.ready       = 1'b0;
  end

  // Watchdog: a run that stops making progress ends here as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver decides at each falling edge whether it takes a placement
  // at the next rising edge. Stalls land on any step of the block's run.
  always @(negedge clk) begin
    if (rst) begin
      cell_ch.ready = 1'b0;
    end else begin
      cell_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Placements are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    placement_t got;
    if (!rst && cell_ch.valid && cell_ch.ready) begin
      got.column = cell_ch.cell_column;
      got.row    = cell_ch.cell_row;
      got.code   = cell_ch.char_code;
      got.last   = cell_ch.last;
      board.check_placement(got);
    end
  end

  // Offers one request and waits for the block to take it. It is entered at a
  // falling edge and returns at a falling edge. Valid is only ever written once
  // per edge, so back-to-back requests keep it high without a glitch.
  task automatic send_request(input logic [3:0] col, input logic [1:0] row,
                              input logic signed [VALUE_BITS-1:0] val,
                              input logic [4:0] width);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.start_column = col;
    req_ch.text_row     = row;
    req_ch.value        = val;
    req_ch.field_width  = width;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(col, row, val, width);
    requests_sent++;
    @(negedge clk);
  endtask

  // Random values lean toward short numbers and the edges of the range, so
  // that both truncation and padding show up often.
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = VALUE_BITS'($urandom);
      4, 5:       v = VALUE_BITS'($urandom_range(99));
      6:          v = VALUE_BITS'($urandom_range(9999));
      7: begin
        case ($urandom_range(3))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          default: v = -16'sd1;
        endcase
      end
      default:    v = VALUE_BITS'($urandom_range(32767));
    endcase
    if ($urandom_range(1) == 1 && v != 16'sh8000) begin
      v = -v;
    end
    return v;
  endfunction

  // Mostly legal widths; a share of zero and of widths above the limit checks
  // the saturation on both sides.
  function automatic logic [4:0] pick_width();
    case ($urandom_range(9))
      0:       return 5'd0;
      1:       return 5'($urandom_range(31, FIELD_MAX + 1));
      2:       return 5'($urandom_range(6, 1));
      default: return 5'($urandom_range(FIELD_MAX, 1));
    endcase
  endfunction

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests: the extremes of every field and the special cases.
    // Zero, shown as a single '0' in the rightmost cell.
    send_request(4'd0, 2'd0, 16'sd0, 5'd8);
    // Zero in a one-cell field lands on the sign cell.
    send_request(4'd15, 2'd3, 16'sd0, 5'd1);
    // Width zero is taken as one; a digit overwrites the sign cell.
    send_request(4'd3, 2'd1, 16'sd7, 5'd0);
    send_request(4'd3, 2'd2, -16'sd7, 5'd0);
    // Widths above the limit saturate, including the all-ones width.
    send_request(4'd15, 2'd3, 16'sd12345, 5'd31);
    send_request(4'd14, 2'd2, -16'sd1, 5'd17);
    send_request(4'd0, 2'd0, 16'sd42, 5'd16);
    // Most negative value shows the digits of its magnitude, padded and
    // exactly filling the field.
    send_request(4'd1, 2'd1, 16'sh8000, 5'd6);
    send_request(4'd2, 2'd2, 16'sh8000, 5'd5);
    send_request(4'd15, 2'd0, 16'sh8000, 5'd16);
    // Largest positive value, fitting beside the sign and cut short.
    send_request(4'd0, 2'd3, 16'sh7FFF, 5'd6);
    send_request(4'd5, 2'd0, 16'sh7FFF, 5'd3);
    // Digits that exactly fill the field overwrite the sign cell.
    send_request(4'd4, 2'd1, 16'sd12345, 5'd5);
    send_request(4'd4, 2'd1, -16'sd12345, 5'd5);
    send_request(4'd6, 2'd2, -16'sd10, 5'd2);
    // Digit boundaries and a one-digit value in a wide field.
    send_request(4'd7, 2'd3, 16'sd9, 5'd4);
    send_request(4'd8, 2'd0, 16'sd10, 5'd4);
    send_request(4'd9, 2'd1, -16'sd99, 5'd4);
    send_request(4'd10, 2'd2, 16'sd100, 5'd2);
    send_request(4'd11, 2'd3, -16'sd1, 5'd2);
    send_request(4'd12, 2'd0, 16'sd5, 5'd1);
    send_request(4'd13, 2'd1, 16'sh5555, 5'd10);
    send_request(4'd10, 2'd2, 16'shAAAA, 5'd10);

    // Random requests in four pacing phases: free flowing, sender gaps,
    // receiver stalls, and both at once.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (RANDOM_REQUESTS / 4) begin
        send_request(4'($urandom_range(15)), 2'($urandom_range(3)), pick_value(),
                     pick_width());
      end
    end
    req_ch.valid = 1'b0;

    // Let every predicted placement arrive, then watch a little longer for
    // anything extra.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d placements across four pacing phases,",
             requests_sent, board.placed);
    $display("with field widths 0 to 31, every start column and row, and value extremes.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
